@@ src/lrn_pkg.sv @@
package lrn_pkg;

  // Default geometry of the feature-map blob
  localparam int DEF_CHANNELS   = 64;
  localparam int DEF_HEIGHT     = 32;
  localparam int DEF_WIDTH      = 32;
  localparam int DEF_MAX_WINDOW = 8;

  // Register reset values
  localparam logic [31:0] ALPHA_RST  = 32'd429497;
  localparam logic [15:0] BETA_RST   = 16'd12288;
  localparam logic [3:0]  WINDOW_RST = 4'd5;

  // Register indexes
  localparam logic [1:0] REG_ALPHA  = 2'd0;
  localparam logic [1:0] REG_BETA   = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  // Command codes
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Sum of squares over up to 16 channels, and alpha*sum/2^16
  localparam int SUM_W = 35;
  localparam int Q_W   = 51;

  typedef struct packed {
    logic [15:0] value;
    logic        sat;
  } lrn_res_t;

  // Floor square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_m;
    v     = v_in;
    res   = '0;
    bit_m = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bit_m) begin
        v   = v - (res + bit_m);
        res = (res >> 1) + bit_m;
      end else begin
        res = res >> 1;
      end
      bit_m = bit_m >> 2;
    end
    return res;
  endfunction

  // Roots 2^(-2^-i) in Q.32, i = 1..16
  function automatic logic [15:0][31:0] build_roots();
    logic [15:0][31:0] tab;
    logic [63:0]       r;
    r = isqrt64(64'd1 << 63);
    for (int i = 0; i < 16; i++) begin
      tab[i] = r[31:0];
      r      = isqrt64(r << 32);
    end
    return tab;
  endfunction

  localparam logic [15:0][31:0] EXP_ROOT = build_roots();

endpackage

@@ src/lrn_math.sv @@
module lrn_math import lrn_pkg::*; #(
  parameter int SZW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   sum_i,
  input  logic signed [15:0] x_i,
  input  logic [SZW-1:0]     size_i,
  input  logic [31:0]        alpha_i,
  input  logic [15:0]        beta_i,
  input  logic               res_ack_i,
  output logic               res_vld_o,
  output lrn_res_t           res_o
);

  localparam int SC_W = Q_W + 1;

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_AMUL  = 4'd1;
  localparam logic [3:0] M_QADD  = 4'd2;
  localparam logic [3:0] M_DIV   = 4'd3;
  localparam logic [3:0] M_SCALE = 4'd4;
  localparam logic [3:0] M_NORM  = 4'd5;
  localparam logic [3:0] M_LSQ   = 4'd6;
  localparam logic [3:0] M_LUPD  = 4'd7;
  localparam logic [3:0] M_EMUL  = 4'd8;
  localparam logic [3:0] M_XMUL  = 4'd9;
  localparam logic [3:0] M_XUPD  = 4'd10;
  localparam logic [3:0] M_FMUL  = 4'd11;
  localparam logic [3:0] M_FRND  = 4'd12;
  localparam logic [3:0] M_DONE  = 4'd13;

  logic [3:0]         st_q, st_d;
  logic [SUM_W-1:0]   sum_q;
  logic signed [15:0] x_q;
  logic [SZW-1:0]     size_q;
  logic [50:0]        phi_q;
  logic [47:0]        plo_q;
  logic [Q_W-1:0]     quo_q;
  logic [SZW-1:0]     rem_q;
  logic [5:0]         cnt_q;
  logic [SC_W-1:0]    scale_q;
  logic [5:0]         k_q;
  logic [31:0]        m_q;
  logic [63:0]        mp_q;
  logic [15:0]        frac_q;
  logic [3:0]         it_q;
  logic [23:0]        e_q;
  logic [32:0]        pw_q;
  logic [64:0]        xp_q;
  logic [48:0]        fp_q;
  lrn_res_t           res_q;

  // Restoring divide step, one quotient bit a cycle
  logic [SZW:0]   rem_sh;
  logic           div_bit;
  logic [SZW-1:0] rem_nx;
  assign rem_sh  = {rem_q, quo_q[Q_W-1]};
  assign div_bit = rem_sh >= {1'b0, size_q};
  assign rem_nx  = div_bit ? SZW'(rem_sh - {1'b0, size_q}) : rem_sh[SZW-1:0];

  // Squaring step of the log
  logic [32:0] lsq;
  assign lsq = mp_q[63:31];

  // Magnitude of the center sample
  logic [15:0] mag;
  assign mag = x_q[15] ? 16'(-x_q) : x_q;

  // Rounding shift, sign and clip
  logic [7:0]         ei;
  logic [5:0]         sh;
  logic [63:0]        rnd_sum;
  logic [63:0]        y_sh;
  logic [16:0]        y;
  logic signed [17:0] sv;
  lrn_res_t           res_c;
  always_comb begin
    ei      = e_q[23:16];
    sh      = {1'b1, ei[4:0]};
    rnd_sum = 64'(fp_q) + (64'd1 << (sh - 6'd1));
    y_sh    = rnd_sum >> sh;
    y       = (|ei[7:5]) ? 17'd0 : y_sh[16:0];
    sv      = x_q[15] ? -$signed({1'b0, y}) : $signed({1'b0, y});
    if (sv > 18'sd32767) begin
      res_c.value = 16'h7FFF;
      res_c.sat   = 1'b1;
    end else if (sv < -18'sd32768) begin
      res_c.value = 16'h8000;
      res_c.sat   = 1'b1;
    end else begin
      res_c.value = sv[15:0];
      res_c.sat   = 1'b0;
    end
  end

  // Sequence the chain
  always_comb begin
    st_d = st_q;
    case (st_q)
      M_IDLE:  if (start_i) st_d = M_AMUL;
      M_AMUL:  st_d = M_QADD;
      M_QADD:  st_d = M_DIV;
      M_DIV:   if (cnt_q == '0) st_d = M_SCALE;
      M_SCALE: st_d = M_NORM;
      M_NORM:  if (!(|scale_q[SC_W-1:33])) st_d = M_LSQ;
      M_LSQ:   st_d = M_LUPD;
      M_LUPD:  st_d = (it_q == 4'd15) ? M_EMUL : M_LSQ;
      M_EMUL:  st_d = M_XMUL;
      M_XMUL:  st_d = M_XUPD;
      M_XUPD:  st_d = (it_q == 4'd15) ? M_FMUL : M_XMUL;
      M_FMUL:  st_d = M_FRND;
      M_FRND:  st_d = M_DONE;
      M_DONE:  if (res_ack_i) st_d = M_IDLE;
      default: st_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= M_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      M_IDLE: begin
        if (start_i) begin
          sum_q  <= sum_i;
          x_q    <= x_i;
          size_q <= size_i;
        end
      end
      M_AMUL: begin
        phi_q <= 51'(alpha_i) * 51'(sum_q[SUM_W-1:16]);
        plo_q <= 48'(alpha_i) * 48'(sum_q[15:0]);
      end
      M_QADD: begin
        quo_q <= Q_W'(phi_q + 51'(plo_q[47:16]));
        rem_q <= '0;
        cnt_q <= 6'(Q_W - 1);
      end
      M_DIV: begin
        quo_q <= {quo_q[Q_W-2:0], div_bit};
        rem_q <= rem_nx;
        cnt_q <= cnt_q - 6'd1;
      end
      M_SCALE: begin
        scale_q <= (SC_W'(1) << 32) + SC_W'(quo_q);
        k_q     <= '0;
      end
      M_NORM: begin
        if (|scale_q[SC_W-1:33]) begin
          scale_q <= scale_q >> 1;
          k_q     <= k_q + 6'd1;
        end else begin
          m_q    <= scale_q[32:1];
          frac_q <= '0;
          it_q   <= '0;
        end
      end
      M_LSQ: mp_q <= 64'(m_q) * 64'(m_q);
      M_LUPD: begin
        if (lsq[32]) begin
          m_q    <= lsq[32:1];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          m_q    <= lsq[31:0];
          frac_q <= {frac_q[14:0], 1'b0};
        end
        it_q <= it_q + 4'd1;
      end
      M_EMUL: begin
        e_q  <= 24'((38'(beta_i) * 38'({k_q, frac_q})) >> 14);
        it_q <= '0;
        pw_q <= 33'h1_0000_0000;
      end
      M_XMUL: xp_q <= 65'(pw_q) * 65'(EXP_ROOT[it_q]);
      M_XUPD: begin
        if (e_q[~it_q]) pw_q <= xp_q[64:32];
        it_q <= it_q + 4'd1;
      end
      M_FMUL: fp_q  <= 49'(mag) * 49'(pw_q);
      M_FRND: res_q <= res_c;
      default: ;
    endcase
  end

  assign res_vld_o = (st_q == M_DONE);
  assign res_o     = res_q;

endmodule

@@ src/lrn_across_channels_core.sv @@
// Store command: the sample is written at the accept edge when the address is in range.
// Compute command: n window reads (one per cycle on the single read port), a drain of
// the square pipeline, then the math chain: a 51-step divide by the window size, up to
// 19 normalize shifts of the scale, log2 by 16 squarings and exp2 by 16 root products,
// then the output register. An out-of-range compute returns zero without reads.
// Reset clears control and loads the register reset values; the feature memory is
// undefined until written.
module lrn_across_channels_core import lrn_pkg::*; #(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int HEIGHT     = DEF_HEIGHT,
  parameter int WIDTH      = DEF_WIDTH,
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // channel[5:0], row[10:6], col[15:11], sample[31:16]
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // norm_value[15:0]
  output logic        m_axis_tuser,  // saturated
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int DEPTH = CHANNELS * HEIGHT * WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SZW   = $clog2(MAX_WINDOW + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MATH  = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [31:0] alpha_q;
  logic [15:0] beta_q;
  logic [3:0]  win_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      beta_q  <= BETA_RST;
      win_q   <= WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ALPHA:  alpha_q <= cfg_data_i;
        REG_BETA:   beta_q  <= cfg_data_i[15:0];
        REG_WINDOW: win_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input decode
  logic [5:0]  s_ch;
  logic [4:0]  s_row;
  logic [4:0]  s_col;
  logic [15:0] s_smp;
  logic        s_fire;
  logic        s_inrange;
  assign s_ch      = s_axis_tdata[5:0];
  assign s_row     = s_axis_tdata[10:6];
  assign s_col     = s_axis_tdata[15:11];
  assign s_smp     = s_axis_tdata[31:16];
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign s_inrange = (32'(s_ch) < 32'(CHANNELS)) && (32'(s_row) < 32'(HEIGHT))
                     && (32'(s_col) < 32'(WIDTH));
  assign s_axis_tready = (state_q == ST_IDLE);

  // Window bounds for the addressed channel
  logic [SZW-1:0]     size_c;
  logic signed [12:0] half_c, start_c, end_c, cnt_c;
  always_comb begin
    if (win_q == 4'd0) size_c = SZW'(1);
    else if (32'(win_q) > 32'(MAX_WINDOW)) size_c = SZW'(MAX_WINDOW);
    else size_c = SZW'(win_q);
    half_c  = 13'((13'(size_c) - 13'sd1) >>> 1);
    start_c = $signed(13'(s_ch)) - half_c;
    end_c   = start_c + $signed(13'(size_c));
    if (end_c > 13'(CHANNELS)) end_c = 13'(CHANNELS);
    if (start_c < 0) start_c = '0;
    cnt_c = end_c - start_c;
  end

  // Element state held across the read sweep
  logic [CIW-1:0] rd_ch_q, ctr_ch_q, iss_ch_q;
  logic [SZW-1:0] rd_left_q, size_q;
  logic [4:0]     row_q, col_q;
  logic           iss_vld_q, sq_vld_q;
  logic [15:0]    rdata_q;
  logic [30:0]    sq_q;
  logic [SUM_W-1:0] acc_q;
  logic signed [15:0] x_q;

  // Feature memory: one write port, one registered read port
  logic [15:0] store_q [DEPTH];
  logic [AW-1:0] waddr, raddr;
  logic          rd_en;
  assign waddr = AW'((AW'(s_ch) * AW'(HEIGHT) + AW'(s_row)) * AW'(WIDTH) + AW'(s_col));
  assign raddr = AW'((AW'(rd_ch_q) * AW'(HEIGHT) + AW'(row_q)) * AW'(WIDTH) + AW'(col_q));
  assign rd_en = (state_q == ST_READ);

  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tuser == CMD_STORE && s_inrange) store_q[waddr] <= s_smp;
    if (rd_en) rdata_q <= store_q[raddr];
  end

  // Math chain
  logic     math_start, math_vld, math_ack, out_free;
  lrn_res_t math_res;
  assign math_start = (state_q == ST_DRAIN) && !iss_vld_q && !sq_vld_q;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign math_ack   = (state_q == ST_MATH) && math_vld && out_free;

  lrn_math #(.SZW(SZW)) u_math (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (math_start),
    .sum_i     (acc_q),
    .x_i       (x_q),
    .size_i    (size_q),
    .alpha_i   (alpha_q),
    .beta_i    (beta_q),
    .res_ack_i (math_ack),
    .res_vld_o (math_vld),
    .res_o     (math_res)
  );

  // Control sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire && s_axis_tuser == CMD_COMPUTE) state_d = s_inrange ? ST_READ : ST_ZERO;
      end
      ST_READ:  if (rd_left_q == SZW'(1)) state_d = ST_DRAIN;
      ST_DRAIN: if (math_start) state_d = ST_MATH;
      ST_MATH:  if (math_ack) state_d = ST_IDLE;
      ST_ZERO:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iss_vld_q <= 1'b0;
      sq_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_vld_q <= rd_en;
      sq_vld_q  <= iss_vld_q;
    end
  end

  // Read sweep, square and accumulate
  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tuser == CMD_COMPUTE) begin
      rd_ch_q   <= CIW'(start_c);
      rd_left_q <= SZW'(cnt_c);
      ctr_ch_q  <= CIW'(s_ch);
      row_q     <= s_row;
      col_q     <= s_col;
      size_q    <= size_c;
      acc_q     <= '0;
    end else begin
      if (rd_en) begin
        rd_ch_q   <= rd_ch_q + CIW'(1);
        rd_left_q <= rd_left_q - SZW'(1);
      end
      if (sq_vld_q) acc_q <= acc_q + SUM_W'(sq_q);
    end
    iss_ch_q <= rd_ch_q;
    if (iss_vld_q) begin
      sq_q <= 31'($signed(rdata_q) * $signed(rdata_q));
      if (iss_ch_q == ctr_ch_q) x_q <= $signed(rdata_q);
    end
  end

  // Output register
  logic     out_vld_q;
  lrn_res_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (math_ack || (state_q == ST_ZERO && out_free)) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (math_ack) out_q <= math_res;
    else if (state_q == ST_ZERO && out_free) out_q <= '0;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.value;
  assign m_axis_tuser  = out_q.sat;

  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (rd_left_q != '0)) else $error("read sweep past window");
  a_square_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_vld_q |=> sq_vld_q) else $error("square stage lost a word");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> !math_vld) else $error("transfer accepted while result pending");
  a_drain_idle_math: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> !math_vld) else $error("math busy during sweep");

endmodule

@@ test/lrn_across_channels_core_tb.sv @@
module lrn_across_channels_core_tb;
  import lrn_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped register index
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 300;
  localparam int HOLD_LEN = 2500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = CMD_STORE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_ALPHA;
  logic [31:0] cfg_data_i = '0;

  lrn_across_channels_core dut (.*);

  // Shadow of the blob and registers
  logic [15:0] fmap_mem [65536];
  bit          fmap_valid [65536];
  logic [31:0] alpha_q;
  logic [15:0] beta_q;
  logic [3:0]  win_q;

  lrn_res_t norm_q [$];
  int  errors = 0;
  int  n_items = 0, n_norm = 0, n_sat_seen = 0;
  bit  sender_quiet = 1'b0, sink_quiet = 1'b0, long_hold = 1'b0;

  typedef struct {
    logic        cmd;
    int          ch, row, col;
    logic [15:0] smp;
    bit          known;
    logic [15:0] exp_val;
  } stim_row_t;

  // Directed rows; known rows carry an expected result of zero
  stim_row_t dir_tab [] = '{
    '{CMD_STORE, 0, 0, 0, 16'h0000, 0, 0}, '{CMD_STORE, 1, 0, 0, 16'h0000, 0, 0},
    '{CMD_STORE, 2, 0, 0, 16'h0000, 0, 0}, '{CMD_STORE, 3, 0, 0, 16'h0000, 0, 0},
    '{CMD_STORE, 4, 0, 0, 16'h0000, 0, 0},
    '{CMD_COMPUTE, 0, 0, 0, 16'h0000, 1, 16'h0000},
    '{CMD_COMPUTE, 2, 0, 0, 16'hffff, 1, 16'h0000},
    '{CMD_STORE, 63, 31, 31, 16'h8000, 0, 0}, '{CMD_STORE, 62, 31, 31, 16'h7fff, 0, 0},
    '{CMD_STORE, 61, 31, 31, 16'h0001, 0, 0}, '{CMD_STORE, 60, 31, 31, 16'hffff, 0, 0},
    '{CMD_STORE, 59, 31, 31, 16'h0000, 0, 0}, '{CMD_STORE, 58, 31, 31, 16'h8000, 0, 0},
    '{CMD_STORE, 57, 31, 31, 16'h7fff, 0, 0},
    '{CMD_COMPUTE, 63, 31, 31, 16'h0000, 0, 0}, '{CMD_COMPUTE, 62, 31, 31, 16'h0000, 0, 0},
    '{CMD_COMPUTE, 61, 31, 31, 16'h0000, 0, 0}, '{CMD_COMPUTE, 60, 31, 31, 16'h0000, 0, 0},
    '{CMD_COMPUTE, 59, 31, 31, 16'h0000, 1, 16'h0000},
    '{CMD_STORE, 0, 0, 0, 16'h7fff, 0, 0},
    '{CMD_COMPUTE, 0, 0, 0, 16'h0000, 0, 0}, '{CMD_COMPUTE, 1, 0, 0, 16'h0000, 1, 16'h0000}
  };

  // Clock and one reset pulse
  initial begin
    forever #5 clk_i = ~clk_i;
  end
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [63:0] floor_root(logic [63:0] v_in);
    logic [63:0] v, res, b;
    v = v_in;
    res = '0;
    b = 64'd1 << 62;
    while (b > v && b != 0) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic int word_addr(int ch, int row, int col);
    return ch * 1024 + row * 32 + col;
  endfunction

  function automatic int clamp_win();
    int size;
    size = win_q;
    if (size < 1) size = 1;
    if (size > 8) size = 8;
    return size;
  endfunction

  function automatic bit window_ready(int ch, int row, int col);
    int size, lo, hi;
    size = clamp_win();
    lo = ch - (size - 1) / 2;
    hi = (lo + size < 64) ? lo + size : 64;
    if (lo < 0) lo = 0;
    for (int i = lo; i < hi; i++)
      if (!fmap_valid[word_addr(i, row, col)]) return 1'b0;
    return 1'b1;
  endfunction

  // Normalize one location: scale^-beta via bit-serial log2 and exp2
  function automatic lrn_res_t predict_norm(int ch, int row, int col);
    int size, lo, hi, lead;
    longint sv, res;
    logic [63:0] sum, q, scale, m, lg, e, p, r, mag, y, sh;
    logic [15:0] frac;
    lrn_res_t o;
    size = clamp_win();
    lo = ch - (size - 1) / 2;
    hi = (lo + size < 64) ? lo + size : 64;
    if (lo < 0) lo = 0;
    sum = '0;
    for (int i = lo; i < hi; i++) begin
      sv = $signed(fmap_mem[word_addr(i, row, col)]);
      sum = sum + 64'(sv * sv);
    end
    q = {32'd0, alpha_q} * (sum >> 16) + (({32'd0, alpha_q} * (sum & 64'hffff)) >> 16);
    scale = (64'd1 << 32) + q / 64'(size);
    lead = 63;
    while (lead > 32 && !scale[lead]) lead--;
    m = scale >> (lead - 31);
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    lg = (64'(lead - 32) << 16) | 64'(frac);
    e = ({48'd0, beta_q} * lg) >> 14;
    p = 64'd1 << 32;
    r = floor_root(64'd1 << 63);
    for (int i = 1; i <= 16; i++) begin
      if (e[16 - i]) p = (p * r) >> 32;
      r = floor_root(r << 32);
    end
    sv = $signed(fmap_mem[word_addr(ch, row, col)]);
    mag = 64'(sv < 0 ? -sv : sv);
    sh = 64'd32 + (e >> 16);
    if (e >= (64'd32 << 16) || sh > 63) y = '0;
    else y = (mag * p + (64'd1 << (sh - 1))) >> sh;
    res = sv < 0 ? -longint'(y) : longint'(y);
    o.sat = 1'b0;
    if (res > 32767) begin
      res = 32767;
      o.sat = 1'b1;
    end else if (res < -32768) begin
      res = -32768;
      o.sat = 1'b1;
    end
    o.value = res[15:0];
    return o;
  endfunction

  task automatic report(string msg);
    errors++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // Drive one item, hold until transfer, then record its effect
  task automatic send_item(logic cmd, int ch, int row, int col, logic [15:0] smp,
                           bit known = 0, logic [15:0] exp_val = '0);
    int gap;
    lrn_res_t o;
    gap = sender_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {smp, col[4:0], row[4:0], ch[5:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    if (cmd == CMD_STORE) begin
      fmap_mem[word_addr(ch, row, col)] = smp;
      fmap_valid[word_addr(ch, row, col)] = 1'b1;
    end else begin
      o = predict_norm(ch, row, col);
      if (known && (o.value != exp_val || o.sat))
        report($sformatf("table value %h differs from predicted %h", exp_val, o.value));
      if (known) begin
        o.value = exp_val;
        o.sat = 1'b0;
      end
      norm_q.push_back(o);
    end
  endtask

  // Drain results and let the block settle before touching registers
  task automatic drain_idle();
    s_axis_tvalid <= 1'b0;
    wait (norm_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_ALPHA) alpha_q = val;
    else if (idx == REG_BETA) beta_q = val[15:0];
    else if (idx == REG_WINDOW) win_q = val[3:0];
  endtask

  task automatic set_params(logic [31:0] a, logic [15:0] b, logic [3:0] w);
    drain_idle();
    write_reg(REG_ALPHA, a);
    write_reg(REG_BETA, {16'd0, b});
    write_reg(REG_WINDOW, {28'd0, w});
  endtask

  function automatic logic [15:0] pick_sample();
    logic [15:0] corner [5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    if ($urandom_range(0, 4) == 0) return corner[$urandom_range(0, 4)];
    return 16'($urandom());
  endfunction

  // Random mix: mostly computes over a fully loaded corner region
  task automatic random_phase(int count);
    int ch, row, col, kind;
    for (int i = 0; i < count; i++) begin
      sender_quiet = (i % 120) < 20;
      sink_quiet = sender_quiet;
      if (i == count / 2 && $urandom_range(0, 1)) begin
        // pause the sender until every result is back
        s_axis_tvalid <= 1'b0;
        wait (norm_q.size() == 0);
      end
      kind = $urandom_range(0, 99);
      ch = $urandom_range(0, 63);
      row = $urandom_range(0, 31);
      col = $urandom_range(0, 31);
      if (kind < 55) begin
        if (!window_ready(ch, row, col)) begin
          row = row[0] ? 31 : 0;
          col = col[0] ? 31 : 0;
        end
        send_item(CMD_COMPUTE, ch, row, col, 16'($urandom()));
      end else begin
        if (kind < 90) begin
          row = row[0] ? 31 : 0;
          col = col[0] ? 31 : 0;
        end
        send_item(CMD_STORE, ch, row, col, pick_sample());
      end
    end
  endtask

  // Stimulus
  initial begin
    alpha_q = ALPHA_RST;
    beta_q  = BETA_RST;
    win_q   = WINDOW_RST;
    wait (rst_ni);
    @(posedge clk_i);
    foreach (dir_tab[k])
      send_item(dir_tab[k].cmd, dir_tab[k].ch, dir_tab[k].row, dir_tab[k].col,
                dir_tab[k].smp, dir_tab[k].known, dir_tab[k].exp_val);
    // load every channel of the four corner locations
    for (int c = 0; c < 64; c++)
      for (int k = 0; k < 4; k++)
        send_item(CMD_STORE, c, k[0] ? 31 : 0, k[1] ? 31 : 0, pick_sample());
    random_phase(200);
    set_params(32'hffff_ffff, 16'hffff, 4'd8);
    long_hold = 1'b1;
    random_phase(200);
    set_params(32'd0, 16'd0, 4'd1);
    drain_idle();
    write_reg(REG_SPARE, 32'hffff_ffff);
    random_phase(200);
    set_params($urandom(), 16'($urandom_range(0, 16384)), 4'd0);
    random_phase(200);
    set_params($urandom(), 16'($urandom()), 4'd15);
    random_phase(200);
    set_params($urandom_range(0, 2000000), 16'($urandom_range(4000, 20000)),
               4'($urandom_range(1, 8)));
    random_phase(236);
    set_params($urandom(), 16'($urandom_range(0, 65535)), 4'($urandom_range(2, 7)));
    random_phase(236);
    s_axis_tvalid <= 1'b0;
    wait (norm_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d items sent, %0d normalized results checked (%0d saturated) over",
             n_items, n_norm, n_sat_seen);
    $display("seven register settings incl. extremes and clamped window sizes");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result sink with random stalls and one long hold-off
  initial begin
    int n;
    wait (rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        long_hold = 1'b0;
      end
      n = sink_quiet ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    lrn_res_t o;
    if (m_axis_tvalid && m_axis_tready) begin
      if (norm_q.size() == 0) begin
        report($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        o = norm_q.pop_front();
        n_norm++;
        if (m_axis_tuser) n_sat_seen++;
        if (m_axis_tdata !== o.value)
          report($sformatf("norm_value %h, want %h", m_axis_tdata, o.value));
        if (m_axis_tuser !== o.sat)
          report($sformatf("saturated %b, want %b", m_axis_tuser, o.sat));
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cnt = 0;
      else
        idle_cnt++;
    end
    $display("watchdog expired, %0d results outstanding", norm_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/lrn_pkg.sv
src/lrn_math.sv
src/lrn_across_channels_core.sv
test/lrn_across_channels_core_tb.sv
